// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Default frame buffer depth in bytes
  localparam int BUF_DEPTH_DEF = 64;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register reset values
  localparam logic [7:0] HEAD_RST  = 8'hAA;
  localparam logic [7:0] TAIL_RST  = 8'h55;
  localparam logic [7:0] ESC_RST   = 8'hA5;
  localparam logic [6:0] SHORT_RST = 7'd17;

  // Lost frame counter saturation point
  localparam logic [15:0] LOST_MAX = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD  = 2'd0,
    REG_TAIL  = 2'd1,
    REG_ESC   = 2'd2,
    REG_SHORT = 2'd3
  } cfg_reg_t;

  // Result status codes
  localparam logic [1:0] ST_GOOD  = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  // Control sequencer
  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  // Channel payloads
  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic        is_last;
    logic [5:0]  frame_length;
    logic [15:0] lost_frames;
  } out_item_t;

endpackage

// ===== rtl/sfr_if.sv =====
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready stream interfaces for the receive byte and result channels.
// ----------------------------------------------------------------------------
interface sfr_in_if import sfr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sfr_frame_buf.sv =====
// ----------------------------------------------------------------------------
// sfr_frame_buf
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfr_frame_buf #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/stuffed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receiver
// Byte-stuffed frame deframer with an 8-bit additive checksum. Frame bytes
// are kept in a buffer memory and a good frame is read back as a run.
// ----------------------------------------------------------------------------
//  channel     dir  handshake           payload
//  in_stream   in   valid/ready         rx_byte
//  out_stream  out  valid/ready         status, payload_byte, is_last,
//                                       frame_length, lost_frames
//  cfg_*       in   cfg_we (no wait)    cfg_index, cfg_wdata
//
//  A received byte is taken while no frame is being read back and the output
//  register is empty or being emptied.
//  A good frame holds off input while its payload is read back: the buffer's
//  single read port delivers one stored byte per cycle unless output stalls.
//  Reset loads the register defaults; the buffer needs no clearing pass.
//  A stalled result holds in the output register; input waits behind it.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver import sfr_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sfr_in_if.sink                in_stream,
  sfr_out_if.source             out_stream,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

  // Configuration registers
  logic [7:0] head_r, tail_r, esc_r;
  logic [6:0] short_r;

  // Frame state
  logic             in_frame_r, in_frame_nxt;
  logic             esc_pend_r, esc_pend_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       last1_r, last1_nxt;
  logic [7:0]       last2_r, last2_nxt;
  logic [15:0]      lost_r, lost_nxt;

  // Sequencer and readout
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              rd_last_r;
  logic [7:0]        rd_data;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Step decode
  logic              accept;
  logic [7:0]        d;
  logic              head_pair, tail_pair, short_frame;
  logic [7:0]        chk_sum;
  logic [15:0]       lost_inc;
  logic              wr_en;
  logic              emit;
  logic [1:0]        emit_status;
  logic              start_drain;
  logic [ADDR_W-1:0] drain_len;
  logic              drain_active, load_out, issue;

  assign d        = in_stream.data.rx_byte;
  assign accept   = in_stream.valid && in_stream.ready;
  assign lost_inc = (lost_r == LOST_MAX) ? lost_r : lost_r + 16'd1;
  // payload sum with the checksum and the first tail taken out
  assign chk_sum  = sum_r - last1_r - last2_r;

  assign head_pair   = (d == head_r) && (prev_r == head_r);
  assign tail_pair   = (d == tail_r) && (prev_r == tail_r) && in_frame_r;
  assign short_frame = (cnt_r != '0) && (CMP_W'(cnt_r) < CMP_W'(short_r));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= HEAD_RST;
      tail_r  <= TAIL_RST;
      esc_r   <= ESC_RST;
      short_r <= SHORT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEAD:  head_r  <= cfg_wdata;
        REG_TAIL:  tail_r  <= cfg_wdata;
        REG_ESC:   esc_r   <= cfg_wdata;
        REG_SHORT: short_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Per-byte frame processing
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_pend_nxt = esc_pend_r;
    prev_nxt     = prev_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    last1_nxt    = last1_r;
    last2_nxt    = last2_r;
    lost_nxt     = lost_r;
    wr_en        = 1'b0;
    emit         = 1'b0;
    emit_status  = ST_BAD;
    start_drain  = 1'b0;
    drain_len    = ADDR_W'(cnt_r - CNT_W'(2));
    if (accept) begin
      if (head_pair) begin
        // restart on a head pair
        in_frame_nxt = 1'b1;
        esc_pend_nxt = 1'b0;
        prev_nxt     = d;
        cnt_nxt      = '0;
        sum_nxt      = '0;
        if (short_frame) begin
          emit        = 1'b1;
          emit_status = ST_SHORT;
          lost_nxt    = lost_inc;
        end
      end else if (tail_pair) begin
        // frame end
        in_frame_nxt = 1'b0;
        esc_pend_nxt = 1'b0;
        prev_nxt     = d;
        cnt_nxt      = '0;
        sum_nxt      = '0;
        if (cnt_r < CNT_W'(2) || chk_sum != last2_r) begin
          emit        = 1'b1;
          emit_status = ST_BAD;
          lost_nxt    = lost_inc;
        end else if (cnt_r != CNT_W'(2)) begin
          start_drain = 1'b1;
        end
      end else begin
        prev_nxt = d;
        if (in_frame_r) begin
          if (!esc_pend_r && d == esc_r) begin
            esc_pend_nxt = 1'b1;
          end else if (cnt_r == CNT_W'(BUF_DEPTH)) begin
            // buffer overflow restarts the frame
            esc_pend_nxt = 1'b0;
            cnt_nxt      = '0;
            sum_nxt      = '0;
            if (short_frame) begin
              emit        = 1'b1;
              emit_status = ST_SHORT;
              lost_nxt    = lost_inc;
            end
          end else begin
            wr_en     = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
            sum_nxt   = sum_r + d;
            last1_nxt = d;
            last2_nxt = last1_r;
            if (esc_pend_r) begin
              esc_pend_nxt = 1'b0;
              prev_nxt     = esc_r;
            end
          end
        end
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start_drain) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (rd_idx_r == len_r && !rd_pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stream.ready = 1'b0;
    drain_active    = 1'b0;
    case (state_r)
      S_IDLE:  in_stream.ready = !out_valid_r || out_stream.ready;
      S_DRAIN: drain_active    = 1'b1;
      default: ;
    endcase
  end

  // Buffer readout: keep one read in flight ahead of the output register
  assign load_out = rd_pend_r && (!out_valid_r || out_stream.ready);
  assign issue    = drain_active && (rd_idx_r != len_r) && (!rd_pend_r || load_out);

  always_comb begin
    rd_idx_nxt  = rd_idx_r;
    len_nxt     = len_r;
    rd_pend_nxt = rd_pend_r;
    if (start_drain) begin
      rd_idx_nxt  = '0;
      len_nxt     = drain_len;
      rd_pend_nxt = 1'b0;
    end else begin
      if (issue) begin
        rd_idx_nxt = rd_idx_r + ADDR_W'(1);
      end
      if (issue) begin
        rd_pend_nxt = 1'b1;
      end else if (load_out) begin
        rd_pend_nxt = 1'b0;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = emit_status;
      out_data_nxt.payload_byte  = '0;
      out_data_nxt.is_last       = 1'b1;
      out_data_nxt.frame_length  = '0;
      out_data_nxt.lost_frames   = lost_nxt;
    end else if (load_out) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = ST_GOOD;
      out_data_nxt.payload_byte  = rd_data;
      out_data_nxt.is_last       = rd_last_r;
      out_data_nxt.frame_length  = 6'(len_r);
      out_data_nxt.lost_frames   = lost_r;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.data  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      esc_pend_r  <= 1'b0;
      prev_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      lost_r      <= '0;
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      esc_pend_r  <= esc_pend_nxt;
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      lost_r      <= lost_nxt;
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    last1_r    <= last1_nxt;
    last2_r    <= last2_nxt;
    rd_idx_r   <= rd_idx_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
    if (issue) begin
      rd_last_r <= (ADDR_W'(rd_idx_r + ADDR_W'(1)) == len_r);
    end
  end

  // Frame byte store
  sfr_frame_buf #(
    .DEPTH  (BUF_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (d),
    .rd_en   (issue),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the stuffed frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker import sfr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Error results are single, empty transactions
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_BAD || out_data.status == ST_SHORT) |->
      out_data.is_last && out_data.payload_byte == 8'd0 &&
      out_data.frame_length == 6'd0)
    else $error("malformed error result");

  // Lost frame count never goes down between results
  a_lost_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid |->
      out_data.lost_frames >= $past(out_data.lost_frames, 1))
    else $error("lost frame count decreased");

  // No byte is taken while a result is stuck in the output register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input taken while output stalled");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_stream.valid),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_data  (out_stream.data)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stuffed frame receiver. Byte-stuffed frames
// (good, bad checksum, missing checksum, abandoned, overflowing, with noise)
// go in through a bursty sender. Results leave through a stalling receiver
// and are checked against a bit-exact deframer predictor. The register set
// changes between idle phases. A final dense run of short abandoned frames
// keeps the sender and receiver at full speed.
// ----------------------------------------------------------------------------
module tb_top;
  import sfr_pkg::*;

  localparam int DEPTH      = BUF_DEPTH_DEF;
  localparam int DRAIN_WAIT = 100;      // cycles past the last result
  localparam int LONG_HOLD  = 400;      // receiver hold-off length
  localparam int PHASE_RX   = 24;       // random bytes per phase
  localparam int LOSS_RUNS  = 10;       // short frames in the dense run
  localparam int LIMIT_CYC  = 2000000;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_NO_SUM,
    FR_ABANDON,
    FR_OVERFLOW
  } frame_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();

  stuffed_frame_receiver #(.BUF_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Bench state
  logic [7:0] pending_rx[$];
  out_item_t  expected_results[$];
  int         rx_queued;
  int         rx_taken;
  int         mismatches;
  logic       hold_req;
  logic       dense;
  int         hold_left;
  int         burst_left;
  int         gap_left;
  logic [7:0] stall_mask;
  int         mask_age;
  out_item_t  want;

  // Register values as last written, for building frames
  logic [7:0] tx_head;
  logic [7:0] tx_tail;
  logic [7:0] tx_esc;

  // Deframer predictor state
  logic [7:0]  reg_head;
  logic [7:0]  reg_tail;
  logic [7:0]  reg_esc;
  logic [6:0]  reg_short;
  logic [7:0]  prev_rx;
  logic        framing;
  logic        esc_armed;
  logic [6:0]  store_cnt;
  logic [7:0]  store_sum;
  logic [7:0]  store_mem [DEPTH];
  logic [15:0] lost_cnt;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Timeout
  initial begin
    #(LIMIT_CYC * 12);
    $display("[stuffed_frame_receiver] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void queue_result(logic [1:0] st, logic [7:0] pb, logic last,
                                       logic [5:0] len);
    out_item_t r;
    r.status       = st;
    r.payload_byte = pb;
    r.is_last      = last;
    r.frame_length = len;
    r.lost_frames  = lost_cnt;
    expected_results.push_back(r);
  endfunction

  function automatic void count_lost();
    if (lost_cnt != LOST_MAX) lost_cnt = lost_cnt + 16'd1;
  endfunction

  // Head pair or overflow: start over, reporting the abandoned frame if short
  function automatic void restart_frame(logic [7:0] b);
    if (store_cnt > 0 && store_cnt < reg_short) begin
      count_lost();
      queue_result(ST_SHORT, 8'h00, 1'b1, 6'd0);
    end
    store_cnt = '0;
    store_sum = '0;
    esc_armed = 1'b0;
    framing   = 1'b1;
    prev_rx   = b;
  endfunction

  function automatic void deframe_byte(logic [7:0] d);
    logic [6:0] n;
    logic [7:0] sum;
    logic [7:0] chk;
    logic [5:0] len;
    if (d == reg_head && prev_rx == reg_head) begin
      restart_frame(d);
      return;
    end
    // Tail pair ends the frame
    if (d == reg_tail && prev_rx == reg_tail && framing) begin
      n         = store_cnt;
      sum       = store_sum;
      framing   = 1'b0;
      esc_armed = 1'b0;
      store_sum = '0;
      store_cnt = '0;
      prev_rx   = d;
      if (n > 0) begin
        n   = n - 7'd1;
        sum = sum - store_mem[6'(n)];
      end
      if (n == 0) begin
        count_lost();
        queue_result(ST_BAD, 8'h00, 1'b1, 6'd0);
        return;
      end
      len = 6'(n - 7'd1);
      chk = store_mem[len];
      sum = sum - chk;
      if (sum != chk) begin
        count_lost();
        queue_result(ST_BAD, 8'h00, 1'b1, 6'd0);
        return;
      end
      for (int k = 0; k < int'(len); k++) begin
        queue_result(ST_GOOD, store_mem[k], (k + 1 == int'(len)), len);
      end
      return;
    end
    prev_rx = d;
    if (!framing) return;
    if (!esc_armed && d == reg_esc) begin
      esc_armed = 1'b1;
      return;
    end
    if (store_cnt >= DEPTH) begin
      restart_frame(d);
      return;
    end
    store_mem[6'(store_cnt)] = d;
    store_cnt = store_cnt + 7'd1;
    store_sum = store_sum + d;
    // An escaped byte never pairs with its neighbor
    if (esc_armed) begin
      esc_armed = 1'b0;
      prev_rx   = reg_esc;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts with random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (pending_rx.size() > 0) begin
        in_if.valid        <= 1'b1;
        in_if.data.rx_byte <= pending_rx.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
          gap_left   <= dense ? 0 : $urandom_range(0, 7);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: rotating stall mask, refreshed now and then
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_mask   <= 8'hFF;
      mask_age     <= 0;
    end else begin
      if (mask_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask <= 8'hFF;
          1:       stall_mask <= 8'($urandom) | 8'h01;
          2:       stall_mask <= 8'($urandom | $urandom) | 8'h01;
          default: stall_mask <= 8'($urandom & $urandom) | 8'h01;
        endcase
        mask_age <= $urandom_range(16, 200);
      end else begin
        stall_mask <= {stall_mask[6:0], stall_mask[7]};
        mask_age   <= mask_age - 1;
      end
      out_if.ready <= (hold_left == 0) && (dense || stall_mask[0]);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results, track register writes, predict accepted bytes
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      reg_head  = HEAD_RST;
      reg_tail  = TAIL_RST;
      reg_esc   = ESC_RST;
      reg_short = SHORT_RST;
      prev_rx   = '0;
      framing   = 1'b0;
      esc_armed = 1'b0;
      store_cnt = '0;
      store_sum = '0;
      lost_cnt  = '0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status=%0d byte=%02h last=%0d len=%0d lost=%0d",
                     out_if.data.status, out_if.data.payload_byte, out_if.data.is_last,
                     out_if.data.frame_length, out_if.data.lost_frames);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_if.data.status       !== want.status       ||
              out_if.data.payload_byte !== want.payload_byte ||
              out_if.data.is_last      !== want.is_last      ||
              out_if.data.frame_length !== want.frame_length ||
              out_if.data.lost_frames  !== want.lost_frames) begin
            if (mismatches < 10)
              $display({"result mismatch: expected status=%0d byte=%02h last=%0d len=%0d",
                        " lost=%0d, got status=%0d byte=%02h last=%0d len=%0d lost=%0d"},
                       want.status, want.payload_byte, want.is_last, want.frame_length,
                       want.lost_frames, out_if.data.status, out_if.data.payload_byte,
                       out_if.data.is_last, out_if.data.frame_length,
                       out_if.data.lost_frames);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAD:  reg_head  = cfg_wdata;
          REG_TAIL:  reg_tail  = cfg_wdata;
          REG_ESC:   reg_esc   = cfg_wdata;
          REG_SHORT: reg_short = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.data.rx_byte);
        rx_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_rx(input logic [7:0] b);
    pending_rx.push_back(b);
    rx_queued++;
  endtask

  task automatic push_pair(input logic [7:0] b);
    push_rx(b);
    push_rx(b);
  endtask

  // Escape anything that could be taken for control
  task automatic push_stuffed(input logic [7:0] b);
    if (b == tx_head || b == tx_tail || b == tx_esc) push_rx(tx_esc);
    push_rx(b);
  endtask

  // Payload byte leaning toward control values and the extremes
  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return tx_head;
      1:       return tx_tail;
      2:       return tx_esc;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Data byte, now and then sent raw to break the stuffing
  task automatic push_data(input logic [7:0] b);
    if ($urandom_range(0, 31) == 0) push_rx(b);
    else push_stuffed(b);
  endtask

  task automatic build_frame(input frame_kind_t kind, input int len);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    push_pair(tx_head);
    case (kind)
      FR_GOOD, FR_BAD_SUM: begin
        for (int i = 0; i < len; i++) begin
          b   = pick_data();
          sum = sum + b;
          push_data(b);
        end
        if (kind == FR_BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
        push_stuffed(sum);
        push_pair(tx_tail);
      end
      FR_NO_SUM: push_pair(tx_tail);
      // left open; the next head pair abandons it
      FR_ABANDON: begin
        for (int i = 0; i < len; i++) push_data(pick_data());
      end
      FR_OVERFLOW: begin
        for (int i = 0; i < DEPTH + 1 + len; i++) push_stuffed(pick_data());
      end
      default: ;
    endcase
  endtask

  task automatic random_traffic(input logic with_hold);
    int          start;
    int          len;
    frame_kind_t kind;
    start = rx_queued;
    while (rx_queued - start < PHASE_RX) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, DEPTH - 2)
                                        : $urandom_range(0, 10);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: kind = FR_GOOD;
        12, 13:                               kind = FR_BAD_SUM;
        14, 15, 16:                           kind = FR_ABANDON;
        17:                                   kind = FR_NO_SUM;
        default:                              kind = FR_OVERFLOW;
      endcase
      if (kind == FR_ABANDON) len = $urandom_range(1, 20);
      if (kind == FR_OVERFLOW) len = $urandom_range(0, 3);
      build_frame(kind, len);
      // line noise between frames, sometimes a stray tail pair
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) push_rx(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) push_pair(tx_tail);
    end
    // receiver holds off while the sender keeps offering
    if (with_hold) begin
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] h, input logic [7:0] t, input logic [7:0] e,
                            input logic [6:0] lim);
    write_reg(REG_HEAD, h);
    write_reg(REG_TAIL, t);
    write_reg(REG_ESC, e);
    write_reg(REG_SHORT, {1'b0, lim});
    tx_head  = h;
    tx_tail  = t;
    tx_esc   = e;
  endtask

  // Block idle: all bytes in, all results out, pipeline settled
  task automatic wait_drained();
    while (rx_taken != rx_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] t;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_HEAD;
    cfg_wdata    = '0;
    hold_req     = 1'b0;
    dense        = 1'b0;
    rx_queued    = 0;
    rx_taken     = 0;
    mismatches   = 0;
    tx_head      = HEAD_RST;
    tx_tail      = TAIL_RST;
    tx_esc       = ESC_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values
    push_pair(tx_tail);                  // tail pair outside a frame
    push_pair(tx_head);
    push_rx(8'h07);
    push_pair(tx_head);                  // one-byte frame abandoned
    push_stuffed(tx_esc);                // escaped escape byte, then 0xFF
    push_stuffed(8'hFF);
    push_stuffed(tx_esc + 8'hFF);
    push_pair(tx_tail);
    push_pair(tx_head);
    push_pair(tx_tail);                  // no checksum byte
    push_pair(tx_head);
    push_rx(8'h00);
    push_pair(tx_tail);                  // empty frame, zero checksum
    push_pair(tx_head);
    push_rx(8'h01);
    push_rx(8'h02);
    push_pair(tx_tail);                  // checksum mismatch
    build_frame(FR_OVERFLOW, 2);         // buffer overflow, short leftover
    random_traffic(1'b1);
    wait_drained();

    // Extreme register values
    set_config(8'h00, 8'hFF, 8'h80, 7'd0);
    random_traffic(1'b0);
    wait_drained();

    set_config(8'hFF, 8'h00, 8'h7F, 7'd64);
    random_traffic(1'b0);
    wait_drained();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 7'($urandom_range(1, 63)));
    random_traffic(1'b1);
    wait_drained();

    // Escape byte doubles as the tail byte
    t = 8'($urandom_range(0, 255));
    set_config(8'($urandom_range(0, 255)), t, t, 7'd1);
    random_traffic(1'b0);
    wait_drained();

    // Dense back-to-back run of short abandoned frames
    set_config(HEAD_RST, TAIL_RST, ESC_RST, 7'd64);
    dense <= 1'b1;
    push_pair(tx_head);
    repeat (LOSS_RUNS) begin
      push_rx(8'($urandom_range(0, 8'h54)));
      push_pair(tx_head);
    end
    push_rx(8'h01);
    push_rx(8'h02);
    push_pair(tx_tail);
    build_frame(FR_GOOD, 3);
    wait_drained();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[stuffed_frame_receiver] OK");
    end else begin
      $display("[stuffed_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule
